// ===== src/lcf_pkg.sv =====
// ----------------------------------------------------------------------------
// lcf_pkg
// Types and constants shared by the line character FIFO modules.
// ----------------------------------------------------------------------------
package lcf_pkg;

    localparam int CNT_W     = 6;
    localparam int CFG_IDX_W = 1;

    localparam logic [7:0] NEWLINE_BYTE  = 8'h0A;
    localparam logic [7:0] DROP_CHAR_RST = 8'h3F;
    localparam logic [7:0] NULL_BYTE     = 8'h00;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_DROP_CHAR   = 1'b0,
        CFG_DROP_ENABLE = 1'b1
    } t_lcf_cfg_idx;

    typedef enum logic [1:0] {
        OP_WRITE = 2'd0,
        OP_READ  = 2'd1,
        OP_LINE  = 2'd2,
        OP_CLEAR = 2'd3
    } t_lcf_op;

    typedef enum logic {
        ST_IDLE = 1'b0,
        ST_LINE = 1'b1
    } t_lcf_state;

    typedef struct packed {
        t_lcf_op    op;
        logic [7:0] data_in;
    } t_lcf_req;

    typedef struct packed {
        logic [7:0]       data_out;
        logic             data_valid;
        logic             overflow;
        logic [CNT_W-1:0] line_count;
        logic [CNT_W-1:0] fill_level;
        logic [CNT_W-1:0] space_left;
        logic             last;
    } t_lcf_rsp;

    typedef struct packed {
        logic [7:0] drop_char;
        logic       drop_enable;
    } t_lcf_cfg;

endpackage

// ===== src/lcf_byte_ram.sv =====
// ----------------------------------------------------------------------------
// lcf_byte_ram
// Byte store: one write port, one read port, registered read, write-first.
// ----------------------------------------------------------------------------
module lcf_byte_ram #(
    parameter int DEPTH = 64,
    parameter int AW    = 6
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [7:0]    i_wdata,
    input  logic [AW-1:0] i_raddr,
    output logic [7:0]    o_rdata
);

    logic [7:0] r_mem [DEPTH];
    logic [7:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // new data wins when the same slot is written and read in one cycle
    always_ff @(posedge i_clk) begin
        if (i_we && (i_waddr == i_raddr)) begin
            r_rdata <= i_wdata;
        end else begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== src/lcf_ctrl.sv =====
// ----------------------------------------------------------------------------
// lcf_ctrl
// Pointer, count and line-streaming control around the byte store.
// ----------------------------------------------------------------------------
module lcf_ctrl
    import lcf_pkg::*;
#(
    parameter int DEPTH = 64,
    parameter int AW    = 6
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          start,
    output logic          busy,
    input  t_lcf_req      i_req,
    input  t_lcf_cfg      i_cfg,
    output logic          o_strobe,
    output t_lcf_rsp      o_rsp,
    output logic          o_we,
    output logic [AW-1:0] o_waddr,
    output logic [7:0]    o_wdata,
    output logic [AW-1:0] o_raddr,
    input  logic [7:0]    i_rdata
);

    t_lcf_state       r_state, n_state;
    logic [AW-1:0]    r_head, n_head;
    logic [AW-1:0]    r_tail, n_tail;
    logic [AW-1:0]    r_fill, n_fill;
    logic [CNT_W-1:0] r_lines, n_lines;
    logic             r_strobe, n_strobe;
    t_lcf_rsp         r_rsp, n_rsp;

    logic accept;
    logic is_full;
    logic dropped;
    logic do_write;
    logic do_ovf;
    logic line_pop;
    logic do_pop;
    logic do_clr;
    logic pop_nl;

    function automatic logic [AW-1:0] wrap_inc(input logic [AW-1:0] p);
        return (p == AW'(DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    assign accept  = start && (r_state == ST_IDLE);
    assign is_full = (r_fill == AW'(DEPTH - 1));
    assign dropped = i_cfg.drop_enable && (i_req.data_in == i_cfg.drop_char);
    assign do_write = accept && (i_req.op == OP_WRITE) && !dropped && !is_full;
    assign do_ovf   = accept && (i_req.op == OP_WRITE) && !dropped && is_full;
    // store output always shows the slot at the head pointer
    assign line_pop = (accept && (i_req.op == OP_LINE) && (r_lines != '0))
                   || (r_state == ST_LINE);
    assign do_pop   = line_pop
                   || (accept && (i_req.op == OP_READ) && (r_fill != '0));
    assign do_clr   = accept && (i_req.op == OP_CLEAR);
    assign pop_nl   = do_pop && (i_rdata == NEWLINE_BYTE);

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (line_pop && (i_rdata != NEWLINE_BYTE) && (r_fill != AW'(1))) begin
                    n_state = ST_LINE;
                end
            end
            ST_LINE: begin
                if ((i_rdata == NEWLINE_BYTE) || (r_fill == AW'(1))) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // pointers, counts and result
    always_comb begin
        n_head  = r_head;
        n_tail  = r_tail;
        n_fill  = r_fill;
        n_lines = r_lines;
        if (do_clr) begin
            n_head  = '0;
            n_tail  = '0;
            n_fill  = '0;
            n_lines = '0;
        end else begin
            if (do_write) begin
                n_tail = wrap_inc(r_tail);
                n_fill = r_fill + 1'b1;
                if (i_req.data_in == NEWLINE_BYTE) begin
                    n_lines = r_lines + 1'b1;
                end
            end
            if (do_pop) begin
                n_head = wrap_inc(r_head);
                n_fill = r_fill - 1'b1;
                if (pop_nl && (r_lines != '0)) begin
                    n_lines = r_lines - 1'b1;
                end
            end
        end

        n_strobe           = accept || (r_state == ST_LINE);
        n_rsp.data_out     = do_pop ? i_rdata : NULL_BYTE;
        n_rsp.data_valid   = do_pop;
        n_rsp.overflow     = do_ovf;
        n_rsp.line_count   = n_lines;
        n_rsp.fill_level   = CNT_W'(n_fill);
        n_rsp.space_left   = CNT_W'(DEPTH - 1) - CNT_W'(n_fill);
        n_rsp.last         = line_pop ? (pop_nl || (n_fill == '0)) : 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_head   <= '0;
            r_tail   <= '0;
            r_fill   <= '0;
            r_lines  <= '0;
            r_strobe <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_head   <= n_head;
            r_tail   <= n_tail;
            r_fill   <= n_fill;
            r_lines  <= n_lines;
            r_strobe <= n_strobe;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rsp <= n_rsp;
    end

    assign busy     = (r_state == ST_LINE);
    assign o_strobe = r_strobe;
    assign o_rsp    = r_rsp;
    assign o_we     = do_write;
    assign o_waddr  = r_tail;
    assign o_wdata  = i_req.data_in;
    assign o_raddr  = n_head;

endmodule

// ===== src/line_character_fifo_unit.sv =====
// ----------------------------------------------------------------------------
// line_character_fifo_unit
// Circular byte FIFO for serial text with line counting and a drop character.
// ----------------------------------------------------------------------------
// Each result strobes in the cycle after the request is accepted.
// Write, read and clear accept a new request every cycle while busy is low.
// Read-line pops one byte per cycle (busy high until the newline goes out),
// paced by the single read port of the byte store.
// Reset clears pointers, counts and config (drop '?', enabled); the store is
// not cleared. Results cannot be stalled by the receiver.
module line_character_fifo_unit
    import lcf_pkg::*;
#(
    parameter int DEPTH = 64
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 start,
    output logic                 busy,
    input  t_lcf_req             i_req,
    output logic                 o_strobe,
    output t_lcf_rsp             o_rsp,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [7:0]           i_cfg_data
);

    localparam int AW = $clog2(DEPTH);

    t_lcf_cfg      r_cfg;
    logic          ram_we;
    logic [AW-1:0] ram_waddr;
    logic [7:0]    ram_wdata;
    logic [AW-1:0] ram_raddr;
    logic [7:0]    ram_rdata;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.drop_char   <= DROP_CHAR_RST;
            r_cfg.drop_enable <= 1'b1;
        end else if (i_cfg_valid) begin
            case (t_lcf_cfg_idx'(i_cfg_index))
                CFG_DROP_CHAR:   r_cfg.drop_char   <= i_cfg_data;
                CFG_DROP_ENABLE: r_cfg.drop_enable <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    lcf_ctrl #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .busy     (busy),
        .i_req    (i_req),
        .i_cfg    (r_cfg),
        .o_strobe (o_strobe),
        .o_rsp    (o_rsp),
        .o_we     (ram_we),
        .o_waddr  (ram_waddr),
        .o_wdata  (ram_wdata),
        .o_raddr  (ram_raddr),
        .i_rdata  (ram_rdata)
    );

    lcf_byte_ram #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

endmodule

// ===== verif/lcf_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// lcf_checker
// Watches the request, result and register channels of the line character
// FIFO, keeps a shadow copy of the buffer, and checks every result strobe
// against the oldest predicted result.
// ----------------------------------------------------------------------------
module lcf_checker
    import lcf_pkg::*;
#(
    parameter int DEPTH = 64
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_start,
    input  logic                 i_busy,
    input  t_lcf_req             i_req,
    input  logic                 i_strobe,
    input  t_lcf_rsp             i_rsp,
    input  logic                 i_cfg_valid,
    input  logic                 i_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [7:0]           i_cfg_data,
    output int                   o_errors,
    output int                   o_pending,
    output int                   o_checked,
    output int                   o_overflows,
    output int                   o_lines_out
);

    // shadow of the buffer and its registers
    logic [7:0] shadow_mem [DEPTH];
    int         rd_ptr;
    int         wr_ptr;
    int         nl_held;
    logic [7:0] drop_ch;
    logic       drop_en;

    t_lcf_rsp   rsp_due [$];
    int         err_cnt;
    int         rsp_cnt;
    int         ovf_cnt;
    int         line_cnt;

    initial begin
        err_cnt   = 0;
        rsp_cnt   = 0;
        ovf_cnt   = 0;
        line_cnt  = 0;
        o_errors  = 0;
        o_pending = 0;
        o_checked = 0;
        o_overflows = 0;
        o_lines_out = 0;
    end

    function automatic int fill_now();
        return (wr_ptr + DEPTH - rd_ptr) % DEPTH;
    endfunction

    function automatic logic [7:0] pop_shadow();
        logic [7:0] b;
        b      = shadow_mem[rd_ptr];
        rd_ptr = (rd_ptr + 1) % DEPTH;
        if (b == NEWLINE_BYTE && nl_held > 0) nl_held--;
        return b;
    endfunction

    task automatic queue_rsp(input logic [7:0] data, input logic valid,
                             input logic ovf, input logic fin);
        t_lcf_rsp r;
        int       fill;
        fill         = fill_now();
        r.data_out   = data;
        r.data_valid = valid;
        r.overflow   = ovf;
        r.line_count = CNT_W'(nl_held);
        r.fill_level = CNT_W'(fill);
        r.space_left = CNT_W'(DEPTH - 1 - fill);
        r.last       = fin;
        rsp_due.push_back(r);
    endtask

    // works out every result one request causes, updating the shadow
    task automatic apply_request(input t_lcf_req rq);
        logic [7:0] b;
        logic       ovf;
        logic       done;
        int         n;
        case (rq.op)
            OP_WRITE: begin
                ovf = 1'b0;
                if (!(drop_en && rq.data_in == drop_ch)) begin
                    if (fill_now() >= DEPTH - 1) begin
                        ovf = 1'b1;
                        ovf_cnt++;
                    end else begin
                        shadow_mem[wr_ptr] = rq.data_in;
                        wr_ptr = (wr_ptr + 1) % DEPTH;
                        if (rq.data_in == NEWLINE_BYTE) nl_held++;
                    end
                end
                queue_rsp(NULL_BYTE, 1'b0, ovf, 1'b1);
            end
            OP_READ: begin
                if (fill_now() == 0) begin
                    queue_rsp(NULL_BYTE, 1'b0, 1'b0, 1'b1);
                end else begin
                    b = pop_shadow();
                    queue_rsp(b, 1'b1, 1'b0, 1'b1);
                end
            end
            OP_LINE: begin
                if (nl_held == 0) begin
                    queue_rsp(NULL_BYTE, 1'b0, 1'b0, 1'b1);
                end else begin
                    n    = 0;
                    done = 1'b0;
                    while (!done && n < DEPTH - 1 && fill_now() > 0) begin
                        b    = pop_shadow();
                        done = (b == NEWLINE_BYTE) || fill_now() == 0;
                        queue_rsp(b, 1'b1, 1'b0, done);
                        n++;
                    end
                    line_cnt++;
                end
            end
            default: begin
                rd_ptr  = 0;
                wr_ptr  = 0;
                nl_held = 0;
                queue_rsp(NULL_BYTE, 1'b0, 1'b0, 1'b1);
            end
        endcase
    endtask

    task automatic report(input string what, input int got, input int want);
        $display("%0t: result %0d %s: got 0x%0h, expected 0x%0h",
                 $realtime, rsp_cnt, what, got, want);
        err_cnt++;
    endtask

    task automatic compare_rsp(input t_lcf_rsp got, input t_lcf_rsp want);
        if (got.data_out !== want.data_out)
            report("data_out", got.data_out, want.data_out);
        if (got.data_valid !== want.data_valid)
            report("data_valid", got.data_valid, want.data_valid);
        if (got.overflow !== want.overflow)
            report("overflow", got.overflow, want.overflow);
        if (got.line_count !== want.line_count)
            report("line_count", got.line_count, want.line_count);
        if (got.fill_level !== want.fill_level)
            report("fill_level", got.fill_level, want.fill_level);
        if (got.space_left !== want.space_left)
            report("space_left", got.space_left, want.space_left);
        if (got.last !== want.last)
            report("last", got.last, want.last);
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            rd_ptr  = 0;
            wr_ptr  = 0;
            nl_held = 0;
            drop_ch = DROP_CHAR_RST;
            drop_en = 1'b1;
            rsp_due.delete();
        end else begin
            if (i_strobe === 1'b1) begin
                if (rsp_due.size() == 0) begin
                    report("with nothing expected", i_rsp, 0);
                end else begin
                    compare_rsp(i_rsp, rsp_due.pop_front());
                end
                rsp_cnt++;
            end
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    CFG_DROP_CHAR:   drop_ch = i_cfg_data;
                    CFG_DROP_ENABLE: drop_en = i_cfg_data[0];
                    default: ;
                endcase
            end
            if (i_start && !i_busy) apply_request(i_req);
        end
        o_errors    <= err_cnt;
        o_pending   <= rsp_due.size();
        o_checked   <= rsp_cnt;
        o_overflows <= ovf_cnt;
        o_lines_out <= line_cnt;
    end

endmodule

// ===== verif/line_character_fifo_unit_test.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// line_character_fifo_unit_test
// Drives directed and random write/read/read-line/clear requests in bursts,
// changes the drop character settings between phases, and lets the checker
// compare every result strobe.
// ----------------------------------------------------------------------------
module line_character_fifo_unit_test;
    import lcf_pkg::*;

    localparam int DEPTH      = 64;
    localparam int LIMIT      = 200000;

    logic                 clk         = 1'b0;
    logic                 rst_n       = 1'b0;
    logic                 start       = 1'b0;
    logic                 busy;
    t_lcf_req             req_r       = '0;
    logic                 strobe;
    t_lcf_rsp             rsp;
    logic                 cfg_valid   = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index   = '0;
    logic [7:0]           cfg_data    = '0;

    int                   errors;
    int                   pending;
    int                   checked;
    int                   overflows;
    int                   lines_out;

    int                   cycles      = 0;
    int                   burst_left  = 0;
    int                   sent        = 0;
    logic [7:0]           cur_drop    = DROP_CHAR_RST;

    line_character_fifo_unit #(
        .DEPTH(DEPTH)
    ) i_dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .start       (start),
        .busy        (busy),
        .i_req       (req_r),
        .o_strobe    (strobe),
        .o_rsp       (rsp),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    lcf_checker #(
        .DEPTH(DEPTH)
    ) i_checker (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_start     (start),
        .i_busy      (busy),
        .i_req       (req_r),
        .i_strobe    (strobe),
        .i_rsp       (rsp),
        .i_cfg_valid (cfg_valid),
        .i_cfg_ready (cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data),
        .o_errors    (errors),
        .o_pending   (pending),
        .o_checked   (checked),
        .o_overflows (overflows),
        .o_lines_out (lines_out)
    );

    initial begin
        forever #5 clk = ~clk;
    end

    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles > LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding", cycles, pending);
            $display("*** FAILED ***");
            $finish;
        end
    end

    // one request; bursts of random length separated by random gaps
    task automatic send(input t_lcf_op op, input logic [7:0] data);
        t_lcf_req rq;
        if (burst_left == 0) begin
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(15, 40)
                                                     : $urandom_range(1, 8);
            if (start) begin
                start <= 1'b0;
                repeat ($urandom_range(1, 6)) @(posedge clk);
            end
        end
        burst_left--;
        rq.op      = op;
        rq.data_in = data;
        start <= 1'b1;
        req_r <= rq;
        do @(posedge clk); while (busy);
        sent++;
    endtask

    // drop start and wait until every predicted result has come out
    task automatic settle();
        if (start) start <= 1'b0;
        burst_left = 0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (3) @(posedge clk);
    endtask

    task automatic write_reg(input t_lcf_cfg_idx idx, input logic [7:0] val);
        settle();
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        if (idx == CFG_DROP_CHAR) cur_drop = val;
    endtask

    task automatic run_random(input int count, input int wr_pct, input int clr_pct);
        int         r;
        int         sel;
        t_lcf_op    op;
        logic [7:0] d;
        for (int n = 0; n < count; n++) begin
            r = $urandom_range(0, 99);
            if (r < wr_pct)                op = OP_WRITE;
            else if (r < wr_pct + clr_pct) op = OP_CLEAR;
            else if (r[0])                 op = OP_READ;
            else                           op = OP_LINE;
            sel = $urandom_range(0, 9);
            if (sel < 2)       d = NEWLINE_BYTE;
            else if (sel == 2) d = cur_drop;
            else               d = 8'($urandom_range(0, 255));
            send(op, d);
        end
    endtask

    initial begin
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: empty reads, extremes, drop char, line handling, clear
        send(OP_READ,  NULL_BYTE);
        send(OP_LINE,  NULL_BYTE);
        send(OP_WRITE, 8'h00);
        send(OP_WRITE, 8'hFF);
        send(OP_WRITE, DROP_CHAR_RST);
        send(OP_LINE,  NULL_BYTE);      // bytes held but no full line
        send(OP_WRITE, NEWLINE_BYTE);
        send(OP_WRITE, 8'h41);
        send(OP_WRITE, NEWLINE_BYTE);
        send(OP_LINE,  NULL_BYTE);
        send(OP_READ,  NULL_BYTE);
        send(OP_LINE,  NULL_BYTE);
        send(OP_READ,  NULL_BYTE);
        send(OP_WRITE, 8'h55);
        send(OP_WRITE, 8'hAA);
        send(OP_CLEAR, NULL_BYTE);
        send(OP_READ,  NULL_BYTE);
        write_reg(CFG_DROP_ENABLE, 8'd0);
        send(OP_WRITE, DROP_CHAR_RST);  // stored now
        send(OP_READ,  NULL_BYTE);
        send(OP_WRITE, 8'h7F);
        send(OP_WRITE, 8'h80);
        send(OP_CLEAR, NULL_BYTE);
        send(OP_WRITE, 8'h01);

        // fill past capacity to hit overflow, pointers wrap afterwards
        write_reg(CFG_DROP_CHAR,   8'h00);
        write_reg(CFG_DROP_ENABLE, 8'd1);
        run_random(72, 100, 0);
        run_random(6, 0, 0);

        write_reg(CFG_DROP_CHAR,   8'hFF);
        write_reg(CFG_DROP_ENABLE, 8'd0);
        run_random(8, 40, 3);

        // newline itself dropped: no new lines can form
        write_reg(CFG_DROP_CHAR,   NEWLINE_BYTE);
        write_reg(CFG_DROP_ENABLE, 8'd1);
        run_random(5, 50, 0);

        write_reg(CFG_DROP_CHAR, 8'($urandom_range(0, 255)));
        run_random(6, 55, 3);

        settle();
        $display("%0d requests sent over several drop settings, %0d results checked",
                 sent, checked);
        $display("%0d overflowing writes and %0d whole lines read out", overflows,
                 lines_out);
        if (errors == 0 && pending == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
